[src/rqfsi_pkg.sv]
// rqfsi_pkg: shared types and constants of the ready queue
// operation codes, per-cell control struct, capacity constants and parameter defaults
// no dependencies
package rqfsi_pkg;

  // parameter defaults
  localparam int DEPTH_DEF    = 16;
  localparam int ID_BITS_DEF  = 8;
  localparam int KEY_BITS_DEF = 16;

  // capacity register
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes carried on in_tuser
  localparam int FUNC_W = 3;
  localparam logic [FUNC_W-1:0] FUNC_FIFO_ENQ   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SORTED_ENQ = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEQUEUE    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PEEK       = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

  // result flags carried on out_tuser
  localparam int OUT_USER_W = 2;

  // per-cell control from the queue controller
  typedef struct packed {
    logic ins;     // an enqueue with room is taking effect
    logic sorted;  // the enqueue is a sorted one
    logic deq;     // a dequeue on a non-empty queue is taking effect
    logic occ;     // this cell holds a live entry
    logic tail;    // this cell is the first free slot
  } cell_ctrl_t;

endpackage

[src/ready_queue_fifo_sorted_insert.sv]
// ready_queue_fifo_sorted_insert: bounded ready queue with fifo and sorted insertion
// top level: request decode, count and capacity registers, chain of rqfsi_cell
// depends on rqfsi_pkg and rqfsi_cell

// Bounded queue of (id, key) entries, head first. Each request on the in_ channel
// carries an operation in in_tuser: fifo enqueue at the tail, sorted enqueue just
// before the first entry with a strictly greater key (equal keys keep arrival
// order), dequeue, peek, or clear. Every request yields exactly one result with
// the count after the operation; out_tuser flags whether an entry was returned
// (id and key are zero otherwise) and whether a full-queue enqueue was dropped.
// The result of a request is registered when it is accepted, and a new request
// is taken every cycle as long as the result register is free or being drained.
// Timing is set by the key compare, which ripples its found flag
// combinationally through all DEPTH cells of the chain. The
// capacity register (values above DEPTH act as DEPTH, zero rejects every
// enqueue) may only be written while no request is outstanding.
module ready_queue_fifo_sorted_insert #(
  parameter int DEPTH    = rqfsi_pkg::DEPTH_DEF,
  parameter int ID_BITS  = rqfsi_pkg::ID_BITS_DEF,
  parameter int KEY_BITS = rqfsi_pkg::KEY_BITS_DEF,
  localparam int CW      = $clog2(DEPTH + 1),
  localparam int IN_DW   = ((ID_BITS + KEY_BITS + 7) / 8) * 8,
  localparam int OUT_DW  = ((ID_BITS + KEY_BITS + CW + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: capacity
  input  logic                             cfg_wen,
  input  logic [rqfsi_pkg::CAP_W-1:0]      cfg_wdata,
  // requests
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_DW-1:0]                 in_tdata,   // proc_id, sort_key, zero pad
  input  logic [rqfsi_pkg::FUNC_W-1:0]     in_tuser,   // func
  // results
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_DW-1:0]                out_tdata,  // out_id, out_key, count, zero pad
  output logic [rqfsi_pkg::OUT_USER_W-1:0] out_tuser   // item_valid, rejected
);

  localparam int IN_PAD  = IN_DW - ID_BITS - KEY_BITS;
  localparam int OUT_PAD = OUT_DW - ID_BITS - KEY_BITS - CW;

  // request fields
  logic                        in_fire;
  logic [ID_BITS-1:0]          req_id;
  logic [KEY_BITS-1:0]         req_key;
  logic [rqfsi_pkg::FUNC_W-1:0] req_func;

  // queue control state
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [rqfsi_pkg::CAP_W-1:0]   cap_r;
  logic                          full, empty;
  logic                          op_ins, op_sorted, op_deq;

  // result register
  logic                out_valid_r;
  logic                item_valid_r, item_valid_nxt;
  logic                rej_r, rej_nxt;
  logic [ID_BITS-1:0]  oid_r, oid_nxt;
  logic [KEY_BITS-1:0] okey_r, okey_nxt;
  logic [CW-1:0]       ocnt_r;

  // cell chain wiring
  logic [ID_BITS-1:0]    cell_id  [DEPTH];
  logic [KEY_BITS-1:0]   cell_key [DEPTH];
  logic [DEPTH:0]        found;
  rqfsi_pkg::cell_ctrl_t cell_ctrl [DEPTH];

  assign req_id   = in_tdata[ID_BITS-1:0];
  assign req_key  = in_tdata[ID_BITS+KEY_BITS-1:ID_BITS];
  assign req_func = in_tuser;

  // result register frees up as it drains
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // full against capacity saturated at the depth
  assign full  = (32'(cnt_r) >= 32'(cap_r)) || (32'(cnt_r) >= 32'(DEPTH));
  assign empty = (cnt_r == '0);

  // decode the request into chain operations and the result
  always_comb begin
    op_ins         = 1'b0;
    op_sorted      = 1'b0;
    op_deq         = 1'b0;
    cnt_nxt        = cnt_r;
    item_valid_nxt = 1'b0;
    rej_nxt        = 1'b0;
    oid_nxt        = '0;
    okey_nxt       = '0;
    case (req_func)
      rqfsi_pkg::FUNC_FIFO_ENQ, rqfsi_pkg::FUNC_SORTED_ENQ: begin
        if (full) begin
          rej_nxt = 1'b1;
        end else begin
          op_ins    = 1'b1;
          op_sorted = (req_func == rqfsi_pkg::FUNC_SORTED_ENQ);
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      rqfsi_pkg::FUNC_DEQUEUE, rqfsi_pkg::FUNC_PEEK: begin
        if (!empty) begin
          // head entry sits in the first cell
          item_valid_nxt = 1'b1;
          oid_nxt        = cell_id[0];
          okey_nxt       = cell_key[0];
          if (req_func == rqfsi_pkg::FUNC_DEQUEUE) begin
            op_deq  = 1'b1;
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      rqfsi_pkg::FUNC_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        // unknown operation: report the count only
      end
    endcase
  end

  // the chain: found ripples from head to tail
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]  l_id, r_id;
    logic [KEY_BITS-1:0] l_key, r_key;

    assign cell_ctrl[i].ins    = in_fire && op_ins;
    assign cell_ctrl[i].sorted = op_sorted;
    assign cell_ctrl[i].deq    = in_fire && op_deq;
    assign cell_ctrl[i].occ    = (CW'(i) < cnt_r);
    assign cell_ctrl[i].tail   = (CW'(i) == cnt_r);

    if (i == 0) begin : g_head
      // nothing to the left of the head ever moves in
      assign l_id  = req_id;
      assign l_key = req_key;
    end else begin : g_mid
      assign l_id  = cell_id[i-1];
      assign l_key = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_id  = cell_id[i];
      assign r_key = cell_key[i];
    end else begin : g_body
      assign r_id  = cell_id[i+1];
      assign r_key = cell_key[i+1];
    end

    rqfsi_cell #(
      .ID_BITS  (ID_BITS),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .new_id    (req_id),
      .new_key   (req_key),
      .left_id   (l_id),
      .left_key  (l_key),
      .right_id  (r_id),
      .right_key (r_key),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .id_q      (cell_id[i]),
      .key_q     (cell_key[i])
    );
  end

  // control state: count, capacity, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cap_r       <= rqfsi_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cap_r <= cfg_wdata;
      end
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_valid_r <= item_valid_nxt;
      rej_r        <= rej_nxt;
      oid_r        <= oid_nxt;
      okey_r       <= okey_nxt;
      ocnt_r       <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, ocnt_r, okey_r, oid_r};
  assign out_tuser  = {rej_r, item_valid_r};

  // upper pad bits of the request carry nothing
  logic unused_pad;
  if (IN_PAD > 0) begin : g_pad
    assign unused_pad = ^in_tdata[IN_DW-1:ID_BITS+KEY_BITS];
  end else begin : g_nopad
    assign unused_pad = 1'b0;
  end

endmodule

[src/rqfsi_cell.sv]
// rqfsi_cell: one slot of the ready queue chain
// holds one entry, compares its key and shifts with its neighbors
// depends on rqfsi_pkg
module rqfsi_cell #(
  parameter int ID_BITS  = rqfsi_pkg::ID_BITS_DEF,
  parameter int KEY_BITS = rqfsi_pkg::KEY_BITS_DEF
) (
  input  logic                   clk,
  input  rqfsi_pkg::cell_ctrl_t  ctrl,
  input  logic [ID_BITS-1:0]     new_id,
  input  logic [KEY_BITS-1:0]    new_key,
  input  logic [ID_BITS-1:0]     left_id,
  input  logic [KEY_BITS-1:0]    left_key,
  input  logic [ID_BITS-1:0]     right_id,
  input  logic [KEY_BITS-1:0]    right_key,
  input  logic                   found_in,
  output logic                   found_out,
  output logic [ID_BITS-1:0]     id_q,
  output logic [KEY_BITS-1:0]    key_q
);

  logic [ID_BITS-1:0]  id_r,  id_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                gt;

  always_comb begin
    gt        = ctrl.occ && (key_r > new_key);
    found_out = found_in || gt;
    id_nxt    = id_r;
    key_nxt   = key_r;
    if (ctrl.ins) begin
      if (ctrl.sorted && found_in) begin
        // slot opened further up: move back by one
        id_nxt  = left_id;
        key_nxt = left_key;
      end else if ((ctrl.sorted && gt) || ctrl.tail) begin
        id_nxt  = new_id;
        key_nxt = new_key;
      end
    end else if (ctrl.deq) begin
      id_nxt  = right_id;
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    key_r <= key_nxt;
  end

  assign id_q  = id_r;
  assign key_q = key_r;

endmodule

[src/rqfsi_checker.sv]
// rqfsi_checker: port-level checks of the ready queue
// bound to ready_queue_fifo_sorted_insert; depends on rqfsi_pkg
module rqfsi_checker #(
  parameter int DEPTH    = rqfsi_pkg::DEPTH_DEF,
  parameter int ID_BITS  = rqfsi_pkg::ID_BITS_DEF,
  parameter int KEY_BITS = rqfsi_pkg::KEY_BITS_DEF,
  localparam int CW      = $clog2(DEPTH + 1),
  localparam int OUT_DW  = ((ID_BITS + KEY_BITS + CW + 7) / 8) * 8
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [OUT_DW-1:0]                out_tdata,
  input logic [rqfsi_pkg::OUT_USER_W-1:0] out_tuser
);

  // a request produces its result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("request accepted without a result on the next cycle");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[ID_BITS+KEY_BITS+CW-1:ID_BITS+KEY_BITS]) <= 32'(DEPTH))
    else $error("count above depth");

  // a returned entry and a rejection never come together; no entry means zero payload
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("entry returned on a rejected enqueue");

  a_empty_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[ID_BITS+KEY_BITS-1:0] == '0)
    else $error("id or key nonzero without a returned entry");

endmodule

bind ready_queue_fifo_sorted_insert rqfsi_checker #(
  .DEPTH    (DEPTH),
  .ID_BITS  (ID_BITS),
  .KEY_BITS (KEY_BITS)
) u_rqfsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[dv/ready_queue_fifo_sorted_insert_tb.sv]
// ready_queue_fifo_sorted_insert_tb: self-checking bench for the bounded ready queue
// drives requests with random gaps, predicts each result and checks it field by field
// depends on rqfsi_pkg and ready_queue_fifo_sorted_insert
`timescale 1ns / 100ps

module ready_queue_fifo_sorted_insert_tb;

  localparam int QDEPTH     = rqfsi_pkg::DEPTH_DEF;
  localparam int IDW        = rqfsi_pkg::ID_BITS_DEF;
  localparam int KEYW       = rqfsi_pkg::KEY_BITS_DEF;
  localparam int FW         = rqfsi_pkg::FUNC_W;
  localparam int CAPW       = rqfsi_pkg::CAP_W;
  localparam int CNTW       = $clog2(QDEPTH + 1);
  localparam int IN_DW      = ((IDW + KEYW + 7) / 8) * 8;
  localparam int OUT_DW     = ((IDW + KEYW + CNTW + 7) / 8) * 8;
  localparam int GAP_MAX    = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 195;
  // codes above clear do nothing but report the count
  localparam logic [FW-1:0]   FUNC_RSVD_FIRST = rqfsi_pkg::FUNC_CLEAR + 1'b1;
  localparam logic [FW-1:0]   FUNC_RSVD_LAST  = {FW{1'b1}};
  localparam logic [CAPW-1:0] CAP_ALL_ONES    = {CAPW{1'b1}};

  typedef struct packed {
    logic             item_valid;
    logic [IDW-1:0]   head_id;
    logic [KEYW-1:0]  head_key;
    logic             rejected;
    logic [CNTW-1:0]  count;
  } queue_result_t;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_wen;
  logic [CAPW-1:0]                  cfg_wdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [IN_DW-1:0]                 in_tdata;   // proc_id, sort_key
  logic [FW-1:0]                    in_tuser;   // func
  logic                             out_tvalid;
  logic                             out_tready;
  logic [OUT_DW-1:0]                out_tdata;  // out_id, out_key, count, zero pad
  logic [rqfsi_pkg::OUT_USER_W-1:0] out_tuser;  // item_valid, rejected

  // shadow copy of the queue, head at index 0
  logic [IDW-1:0]   shadow_ids[QDEPTH];
  logic [KEYW-1:0]  shadow_keys[QDEPTH];
  int               shadow_count;
  logic [CAPW-1:0]  shadow_cap;

  queue_result_t pending_results[$];
  int            error_count;
  int            result_index;
  int            cycle_count;
  int            send_gap_max;
  int            recv_gap_max;
  int            recv_hold_cycles;

  ready_queue_fifo_sorted_insert uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs on either handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("result %0d: %s", result_index, msg);
    error_count++;
  endtask

  // works out the result of one accepted request and updates the shadow queue
  task automatic predict_queue_op(input logic [FW-1:0] func, input logic [IDW-1:0] id,
                                  input logic [KEYW-1:0] key);
    queue_result_t r;
    int            room;
    int            pos;
    r = '0;
    room = (shadow_cap > QDEPTH) ? QDEPTH : int'(shadow_cap);
    case (func)
      rqfsi_pkg::FUNC_FIFO_ENQ, rqfsi_pkg::FUNC_SORTED_ENQ: begin
        if (shadow_count >= room) begin
          r.rejected = 1'b1;
        end else begin
          pos = shadow_count;
          // sorted: in front of the first strictly greater key, so ties keep arrival order
          if (func == rqfsi_pkg::FUNC_SORTED_ENQ) begin
            for (int i = shadow_count - 1; i >= 0; i--) begin
              if (shadow_keys[i] > key) pos = i;
            end
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_ids[i]  = shadow_ids[i-1];
            shadow_keys[i] = shadow_keys[i-1];
          end
          shadow_ids[pos]  = id;
          shadow_keys[pos] = key;
          shadow_count++;
        end
      end
      rqfsi_pkg::FUNC_DEQUEUE, rqfsi_pkg::FUNC_PEEK: begin
        if (shadow_count > 0) begin
          r.item_valid = 1'b1;
          r.head_id    = shadow_ids[0];
          r.head_key   = shadow_keys[0];
          if (func == rqfsi_pkg::FUNC_DEQUEUE) begin
            for (int i = 1; i < shadow_count; i++) begin
              shadow_ids[i-1]  = shadow_ids[i];
              shadow_keys[i-1] = shadow_keys[i];
            end
            shadow_count--;
          end
        end
      end
      rqfsi_pkg::FUNC_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.count = shadow_count[CNTW-1:0];
    pending_results.push_back(r);
  endtask

  // one request: optional gap, then hold it up until the block takes it.
  // valid is left high after acceptance; the next call or idle_input drives it again
  task automatic send_request(input logic [FW-1:0] func, input logic [IDW-1:0] id,
                              input logic [KEYW-1:0] key);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= IN_DW'({key, id});
    do @(posedge clk); while (!in_tready);
    predict_queue_op(func, id, key);
  endtask

  task automatic idle_input();
    @(negedge clk) in_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // capacity only changes with nothing in flight
  task automatic write_capacity(input logic [CAPW-1:0] value);
    idle_input();
    wait_results_drained();
    repeat (2) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    shadow_cap = value;
    @(negedge clk) cfg_wen <= 1'b0;
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      if (recv_hold_cycles > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (recv_hold_cycles - 1) @(negedge clk);
        recv_hold_cycles = 0;
      end
      stall = $urandom_range(0, recv_gap_max);
      if (stall > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.item_valid)
          report_mismatch($sformatf("item_valid got %b expected %b", out_tuser[0],
                                    want.item_valid));
        if (out_tdata[IDW-1:0] !== want.head_id)
          report_mismatch($sformatf("out_id got 0x%0h expected 0x%0h", out_tdata[IDW-1:0],
                                    want.head_id));
        if (out_tdata[IDW+KEYW-1:IDW] !== want.head_key)
          report_mismatch($sformatf("out_key got 0x%0h expected 0x%0h",
                                    out_tdata[IDW+KEYW-1:IDW], want.head_key));
        if (out_tuser[1] !== want.rejected)
          report_mismatch($sformatf("rejected got %b expected %b", out_tuser[1],
                                    want.rejected));
        if (out_tdata[IDW+KEYW+CNTW-1:IDW+KEYW] !== want.count)
          report_mismatch($sformatf("count got %0d expected %0d",
                                    out_tdata[IDW+KEYW+CNTW-1:IDW+KEYW], want.count));
      end
      result_index++;
    end
  end

  // empty-queue reads, field extremes, sorted ties, unused codes and clear
  task automatic test_basic_ops();
    send_request(rqfsi_pkg::FUNC_PEEK, 8'hA5, 16'h5A5A);
    send_request(rqfsi_pkg::FUNC_DEQUEUE, 8'hFF, 16'hFFFF);
    send_request(rqfsi_pkg::FUNC_FIFO_ENQ, 8'h00, 16'h0000);
    send_request(rqfsi_pkg::FUNC_FIFO_ENQ, 8'hFF, 16'hFFFF);
    send_request(rqfsi_pkg::FUNC_SORTED_ENQ, 8'h11, 16'h8000);
    // equal key lands behind the earlier one
    send_request(rqfsi_pkg::FUNC_SORTED_ENQ, 8'h22, 16'h8000);
    // key zero is not greater than the stored zero, so it goes second
    send_request(rqfsi_pkg::FUNC_SORTED_ENQ, 8'h33, 16'h0000);
    for (int f = FUNC_RSVD_FIRST; f <= FUNC_RSVD_LAST; f++)
      send_request(FW'(f), 8'hFF, 16'hFFFF);
    send_request(rqfsi_pkg::FUNC_PEEK, 8'h00, 16'h0000);
    repeat (3) send_request(rqfsi_pkg::FUNC_DEQUEUE, 8'h00, 16'h0000);
    send_request(rqfsi_pkg::FUNC_CLEAR, 8'hFF, 16'hFFFF);
    send_request(rqfsi_pkg::FUNC_DEQUEUE, 8'h00, 16'h0000);
  endtask

  // capacity of one, zero, and lowered under the current count
  task automatic test_capacity_edges();
    write_capacity(5'd1);
    send_request(rqfsi_pkg::FUNC_FIFO_ENQ, 8'h5A, 16'h1234);
    send_request(rqfsi_pkg::FUNC_SORTED_ENQ, 8'hA5, 16'h0001);
    send_request(rqfsi_pkg::FUNC_DEQUEUE, 8'h00, 16'h0000);
    write_capacity('0);
    send_request(rqfsi_pkg::FUNC_SORTED_ENQ, 8'h01, 16'h0002);
    send_request(rqfsi_pkg::FUNC_PEEK, 8'h00, 16'h0000);
    write_capacity(rqfsi_pkg::CAP_RESET);
    repeat (3) send_request(rqfsi_pkg::FUNC_SORTED_ENQ, 8'($urandom), 16'($urandom));
    write_capacity(5'd2);
    send_request(rqfsi_pkg::FUNC_FIFO_ENQ, 8'h77, 16'h7777);
    send_request(rqfsi_pkg::FUNC_DEQUEUE, 8'h00, 16'h0000);
    send_request(rqfsi_pkg::FUNC_FIFO_ENQ, 8'h78, 16'h7778);
    send_request(rqfsi_pkg::FUNC_DEQUEUE, 8'h00, 16'h0000);
    send_request(rqfsi_pkg::FUNC_SORTED_ENQ, 8'h79, 16'h0000);
    send_request(rqfsi_pkg::FUNC_CLEAR, 8'h00, 16'h0000);
  endtask

  // random request with a bias toward filling or draining the queue
  task automatic send_random_request(input int enq_pct);
    int               r;
    logic [FW-1:0]    func;
    logic [KEYW-1:0]  key;
    r = $urandom_range(0, 99);
    if (r < 2)
      func = rqfsi_pkg::FUNC_CLEAR;
    else if (r < 4)
      func = FW'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
    else if ($urandom_range(0, 99) < enq_pct)
      func = $urandom_range(0, 1) ? rqfsi_pkg::FUNC_SORTED_ENQ : rqfsi_pkg::FUNC_FIFO_ENQ;
    else
      func = ($urandom_range(0, 3) == 0) ? rqfsi_pkg::FUNC_PEEK : rqfsi_pkg::FUNC_DEQUEUE;
    // narrow keys give plenty of ties for the sorted insert
    key = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7));
    send_request(func, 8'($urandom), key);
  endtask

  task automatic test_random_phases();
    logic [CAPW-1:0] caps[RAND_PHASES];
    caps = '{rqfsi_pkg::CAP_RESET, CAP_ALL_ONES, 5'd5, 5'd17, 5'd1, 5'd12, 5'd3};
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_capacity(caps[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // change pacing every so often, sometimes running flat out
        if (n % 50 == 0) begin
          send_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
          recv_gap_max = $urandom_range(0, 1) ? GAP_MAX : 0;
        end
        send_random_request(((n / 40) % 2 == 0) ? 75 : 30);
      end
    end
    send_gap_max = GAP_MAX;
    recv_gap_max = GAP_MAX;
  endtask

  // long receiver hold-off while requests keep coming back to back
  task automatic test_backpressure();
    write_capacity(rqfsi_pkg::CAP_RESET);
    send_gap_max = 0;
    recv_hold_cycles = 300;
    repeat (40) send_random_request(70);
    send_gap_max = GAP_MAX;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_wen          = 1'b0;
    cfg_wdata        = '0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = '0;
    error_count      = 0;
    result_index     = 0;
    cycle_count      = 0;
    send_gap_max     = GAP_MAX;
    recv_gap_max     = GAP_MAX;
    recv_hold_cycles = 0;
    shadow_count     = 0;
    shadow_cap       = rqfsi_pkg::CAP_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_basic_ops();
    test_capacity_edges();
    test_random_phases();
    test_backpressure();

    idle_input();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/rqfsi_pkg.sv
src/rqfsi_cell.sv
src/ready_queue_fifo_sorted_insert.sv
src/rqfsi_checker.sv
dv/ready_queue_fifo_sorted_insert_tb.sv
